### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, masked while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

// Next-cycle implication that also holds across reset.
`define CHK_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("check failed");

`endif

### rtl/csmm_pkg.sv
`default_nettype none
package csmm_pkg;

   localparam int unsigned PIXEL_W    = 8;
   localparam int unsigned FULL_SCALE = 255;
   localparam int unsigned DIV_STEPS  = PIXEL_W;
   localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS);

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_SATURATE
   } state_type;

   // Operands of one restoring-division step
   typedef struct packed {
      logic [PIXEL_W-1:0] rem;
      logic [PIXEL_W-1:0] quo;
      logic [PIXEL_W-1:0] divisor;
   } div_step_in_type;

   // Result of one restoring-division step
   typedef struct packed {
      logic [PIXEL_W-1:0] rem;
      logic [PIXEL_W-1:0] quo;
   } div_step_out_type;

endpackage
`default_nettype wire

### rtl/csmm_div_step.sv
`default_nettype none
// One restoring-division step: shift in the next dividend bit, compare,
// subtract, emit one quotient bit.
module csmm_div_step (
   input  wire  csmm_pkg::div_step_in_type  step_i,
   output       csmm_pkg::div_step_out_type step_o
);

   logic [csmm_pkg::PIXEL_W:0] trial;
   logic [csmm_pkg::PIXEL_W:0] diff;
   logic                       ge;

   always_comb begin
      trial = {step_i.rem, step_i.quo[csmm_pkg::PIXEL_W-1]};
      ge    = (trial >= {1'b0, step_i.divisor});
      diff  = trial - {1'b0, step_i.divisor};
      // remainder stays below the divisor, so it fits the low bits
      step_o.rem = ge ? diff[csmm_pkg::PIXEL_W-1:0] : trial[csmm_pkg::PIXEL_W-1:0];
      step_o.quo = {step_i.quo[csmm_pkg::PIXEL_W-2:0], ge};
   end

endmodule
`default_nettype wire

### rtl/contrast_stretch_min_max_core.sv
`default_nettype none
// Min/max contrast stretch for 8-bit grey frames.
// Input channel req_*: req_kind = 0 is a measure-pass pixel, 1 a map-pass
// pixel. A frame is sent once as measure items, then again as map items.
// Result channel rsp_*: one rsp_mapped_pixel per map item, none per measure.
// Measure items update min/max when accepted; the sequencer stays idle.
// A map item steps the sequencer through accept, multiply and saturate; its
// result is registered in the saturate step, then the sequencer is idle.
// The first map item after a measure pass also runs the gain division,
// 255 / (max - min), on a shared compare/subtract step, one quotient bit
// per cycle, before the multiply step.
// Flat frames skip the division. req_ready is high only while idle.
// Results sit in an output register; a stalled receiver holds the result
// there, and the block keeps accepting measure items meanwhile. A map item
// waits in its saturate step until the output register is free.
// Reset: min = 0, max = 255, gain = 1, mapping phase set, output empty.
module contrast_stretch_min_max_core (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire        req_kind,
   input  wire  [7:0] req_pixel,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [7:0] rsp_mapped_pixel
);

   localparam int unsigned PW = csmm_pkg::PIXEL_W;

   csmm_pkg::state_type state_ff, state_in;

   logic [PW-1:0] low_ff, low_in;
   logic [PW-1:0] high_ff, high_in;
   logic [PW-1:0] gain_ff, gain_in;
   logic          mapping_ff, mapping_in;
   logic [PW-1:0] pix_ff, pix_in;
   logic [PW-1:0] rem_ff, rem_in;
   logic [PW-1:0] quo_ff, quo_in;
   logic [csmm_pkg::STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [2*PW+1:0] prod_ff, prod_in;
   logic          out_valid_ff, out_valid_in;
   logic [PW-1:0] out_pix_ff, out_pix_in;

   logic req_fire;
   logic out_free;
   logic flat;
   logic signed [PW:0]     diff_s;
   logic signed [2*PW+2:0] val_s;

   csmm_pkg::div_step_in_type  step_in;
   csmm_pkg::div_step_out_type step_out;

   assign req_fire = req_valid && req_ready;
   assign out_free = !out_valid_ff || rsp_ready;
   assign flat     = (high_ff == low_ff);

   // Shared division step
   assign step_in.rem     = rem_ff;
   assign step_in.quo     = quo_ff;
   assign step_in.divisor = high_ff - low_ff;

   csmm_div_step u_div_step (
      .step_i (step_in),
      .step_o (step_out)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csmm_pkg::ST_IDLE: begin
            if (req_fire && req_kind) begin
               if (!mapping_ff && !flat) state_in = csmm_pkg::ST_DIVIDE;
               else                      state_in = csmm_pkg::ST_MULTIPLY;
            end
         end
         csmm_pkg::ST_DIVIDE: begin
            if (cnt_ff == csmm_pkg::STEP_CNT_W'(csmm_pkg::DIV_STEPS - 1))
               state_in = csmm_pkg::ST_MULTIPLY;
         end
         csmm_pkg::ST_MULTIPLY: state_in = csmm_pkg::ST_SATURATE;
         csmm_pkg::ST_SATURATE: begin
            if (out_free) state_in = csmm_pkg::ST_IDLE;
         end
         default: state_in = csmm_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      req_ready    = (state_ff == csmm_pkg::ST_IDLE);
      low_in       = low_ff;
      high_in      = high_ff;
      gain_in      = gain_ff;
      mapping_in   = mapping_ff;
      pix_in       = pix_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      out_pix_in   = out_pix_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      diff_s       = $signed({1'b0, high_ff}) - $signed({1'b0, pix_ff});
      val_s        = $signed((2*PW+3)'(csmm_pkg::FULL_SCALE)) - (2*PW+3)'(prod_ff);

      unique case (state_ff)
         csmm_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (!req_kind) begin
                  // measure: restart after a map pass, else track min/max
                  if (mapping_ff) begin
                     low_in     = req_pixel;
                     high_in    = req_pixel;
                     mapping_in = 1'b0;
                  end else begin
                     if (req_pixel < low_ff)  low_in  = req_pixel;
                     if (req_pixel > high_ff) high_in = req_pixel;
                  end
               end else begin
                  pix_in     = req_pixel;
                  mapping_in = 1'b1;
                  rem_in     = '0;
                  quo_in     = PW'(csmm_pkg::FULL_SCALE);
                  cnt_in     = '0;
               end
            end
         end
         csmm_pkg::ST_DIVIDE: begin
            rem_in = step_out.rem;
            quo_in = step_out.quo;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == csmm_pkg::STEP_CNT_W'(csmm_pkg::DIV_STEPS - 1))
               gain_in = step_out.quo;
         end
         csmm_pkg::ST_MULTIPLY: begin
            prod_in = (2*PW+2)'($signed({1'b0, gain_ff})) * (2*PW+2)'(diff_s);
         end
         csmm_pkg::ST_SATURATE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (flat)
                  out_pix_in = pix_ff;
               else if (val_s < 0)
                  out_pix_in = '0;
               else if (val_s > $signed((2*PW+3)'(csmm_pkg::FULL_SCALE)))
                  out_pix_in = PW'(csmm_pkg::FULL_SCALE);
               else
                  out_pix_in = val_s[PW-1:0];
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_mapped_pixel = out_pix_ff;

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csmm_pkg::ST_IDLE;
         low_ff       <= '0;
         high_ff      <= PW'(csmm_pkg::FULL_SCALE);
         gain_ff      <= PW'(1);
         mapping_ff   <= 1'b1;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         gain_ff      <= gain_in;
         mapping_ff   <= mapping_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pix_ff     <= pix_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      prod_ff    <= prod_in;
      out_pix_ff <= out_pix_in;
   end

endmodule
`default_nettype wire

### rtl/csmm_checker.sv
`default_nettype none
`include "assert_macros.svh"
// Port-level checks for the contrast stretch core.
module csmm_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       req_kind,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] rsp_mapped_pixel
);

   // a stalled result stays offered and unchanged
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_mapped_pixel))
   // reset empties the output register
   `CHK_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_valid)
   // a map transaction occupies the sequencer for the next cycle
   `CHK_NEXT(a_map_busy, clock, reset, req_valid && req_ready && req_kind, !req_ready)
   // a measure transaction never produces a result
   `CHK_NEXT(a_meas_quiet, clock, reset, req_valid && req_ready && !req_kind && !rsp_valid, !rsp_valid)

endmodule

bind contrast_stretch_min_max_core csmm_checker u_csmm_checker (.*);
`default_nettype wire

### verif/tb_contrast_stretch_min_max_core.sv
`default_nettype none
module tb_contrast_stretch_min_max_core;

   localparam bit KIND_MEASURE   = 1'b0;
   localparam bit KIND_MAP       = 1'b1;
   localparam int IDLE_PCT       = 32;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int SETTLE_CYCLES  = 40;

   // Stretch predictor plus queue of mapped pixels still owed by the block
   class stretch_scoreboard;
      logic [7:0] low_level;
      logic [7:0] high_level;
      logic [7:0] gain;
      bit         mapping;
      logic [7:0] expected_pixels[$];
      int         errors;

      function new();
         low_level  = 8'd0;
         high_level = 8'd255;
         gain       = 8'd1;
         mapping    = 1'b1;
         errors     = 0;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // Flat range passes the pixel through; otherwise gain slope, clamped
      function logic [7:0] stretch(logic [7:0] pix);
         int diff;
         int val;
         if (high_level == low_level) return pix;
         diff = int'(high_level) - int'(pix);
         val  = int'(csmm_pkg::FULL_SCALE) - int'(gain) * diff;
         if (val < 0) val = 0;
         if (val > int'(csmm_pkg::FULL_SCALE)) val = int'(csmm_pkg::FULL_SCALE);
         return val[7:0];
      endfunction

      // Update state for one accepted request transaction
      function void note_request(bit kind, logic [7:0] pix);
         if (kind == KIND_MEASURE) begin
            if (mapping) begin
               low_level  = pix;
               high_level = pix;
               mapping    = 1'b0;
            end else begin
               if (pix < low_level) low_level = pix;
               if (pix > high_level) high_level = pix;
            end
         end else begin
            // first map item after a measure pass latches a new gain unless the range is flat
            if (!mapping) begin
               if (high_level != low_level)
                  gain = 8'(csmm_pkg::FULL_SCALE / int'(high_level - low_level));
               mapping = 1'b1;
            end
            expected_pixels.push_back(stretch(pix));
         end
      endfunction

      task report_mismatch(string msg);
         $display("ERROR @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic [7:0] got);
         logic [7:0] want;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("mapped_pixel %0d with nothing outstanding", got));
         end else begin
            want = expected_pixels.pop_front();
            if (got !== want)
               report_mismatch($sformatf("mapped_pixel %0d, want %0d", got, want));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_kind = 1'b0;
   logic [7:0] req_pixel = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_mapped_pixel;

   stretch_scoreboard sb = new();
   int  sent = 0;
   bit  quiet = 1'b0;
   bit  hold_request = 1'b0;

   contrast_stretch_min_max_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mapped_pixel (rsp_mapped_pixel)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one pixel, with random idle cycles first, and wait for acceptance
   task send_pixel(input bit kind, input logic [7:0] pix);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_pixel <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(kind, pix);
      sent++;
   endtask

   task drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // One frame: measure pass over a chosen range, then a map pass
   task send_frame(input int n_measure, input int n_map);
      int lo;
      int hi;
      int shape;
      shape = $urandom_range(3);
      lo    = $urandom_range(255);
      case (shape)
         0: hi = lo;
         1: hi = (lo > 247) ? 255 : lo + $urandom_range(1, 8);
         default: hi = $urandom_range(255, lo);
      endcase
      repeat (n_measure) send_pixel(KIND_MEASURE, 8'($urandom_range(hi, lo)));
      repeat (n_map) begin
         if ($urandom_range(99) < 85)
            send_pixel(KIND_MAP, 8'($urandom_range(hi, lo)));
         else
            send_pixel(KIND_MAP, 8'($urandom_range(255)));
      end
   endtask

   // Receiver: random stalls, plus one long hold when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Result monitor
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_mapped_pixel);
      end
   end

   initial begin
      #4_000_000;
      $display("contrast_stretch_min_max_core verification failed");
      $finish;
   end

   // Stimulus
   initial begin
      bit pressed;
      bit paused;
      int r;
      pressed = 1'b0;
      paused  = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // map with no measure pass: identity through reset gain
      send_pixel(KIND_MAP, 8'd0);
      send_pixel(KIND_MAP, 8'd255);
      send_pixel(KIND_MAP, 8'd128);
      // full range, gain of one
      send_pixel(KIND_MEASURE, 8'd0);
      send_pixel(KIND_MEASURE, 8'd255);
      send_pixel(KIND_MAP, 8'd0);
      send_pixel(KIND_MAP, 8'd255);
      send_pixel(KIND_MAP, 8'd77);
      // measure after mapping restarts; range of one gives largest gain
      send_pixel(KIND_MEASURE, 8'd100);
      send_pixel(KIND_MEASURE, 8'd101);
      send_pixel(KIND_MAP, 8'd101);
      send_pixel(KIND_MAP, 8'd100);
      send_pixel(KIND_MAP, 8'd99);
      send_pixel(KIND_MAP, 8'd200);
      // flat frame passes pixels through
      send_pixel(KIND_MEASURE, 8'd50);
      send_pixel(KIND_MAP, 8'd50);
      send_pixel(KIND_MAP, 8'd0);
      send_pixel(KIND_MAP, 8'd255);
      // mid range, pixels below and above the measured range saturate
      send_pixel(KIND_MEASURE, 8'd10);
      send_pixel(KIND_MEASURE, 8'd60);
      send_pixel(KIND_MAP, 8'd35);
      send_pixel(KIND_MAP, 8'd5);
      send_pixel(KIND_MAP, 8'd61);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet = (sent >= 900 && sent < 1100);
         if (!pressed && sent >= 300) begin
            // long receiver hold while requests keep coming
            pressed = 1'b1;
            hold_request = 1'b1;
            send_frame(4, 30);
         end else if (!paused && sent >= 700) begin
            paused = 1'b1;
            drain_results();
         end
         r = $urandom_range(99);
         if (r < 75) begin
            send_frame($urandom_range(1, 12), $urandom_range(1, 12));
         end else begin
            repeat ($urandom_range(1, 8))
               send_pixel(1'($urandom_range(1)), 8'($urandom_range(255)));
         end
      end
      quiet = 1'b0;

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("contrast_stretch_min_max_core verification clean");
      end else begin
         $display("contrast_stretch_min_max_core verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/csmm_pkg.sv
rtl/csmm_div_step.sv
rtl/contrast_stretch_min_max_core.sv
rtl/csmm_checker.sv
verif/tb_contrast_stretch_min_max_core.sv
